FILE: sv/mhsi_pkg.sv
// Shared constants and lane control type for the magnetometer calibrator.
`timescale 1ns / 1ps

package mhsi_pkg;

   localparam int AXES                = 3;
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int SCALE_FRAC_BITS_DEF = 12;
   localparam int SCALE_BITS          = 16;

   typedef struct packed {
      logic update;   // fold the new sample into min/max
      logic start;    // load the divider
      logic step;     // one restoring-division step
   } lane_ctrl_type;

endpackage

FILE: sv/mhsi_lane.sv
// One axis lane: running min/max, midpoint, span and a bit-serial scale divider.
`timescale 1ns / 1ps

module mhsi_lane #(
   parameter int SAMPLE_BITS     = mhsi_pkg::SAMPLE_BITS_DEF,
   parameter int SCALE_FRAC_BITS = mhsi_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mhsi_pkg::lane_ctrl_type             ctrl,
   input  logic signed [SAMPLE_BITS-1:0]       sample,
   input  logic        [SAMPLE_BITS-1:0]       widest,
   output logic signed [SAMPLE_BITS-1:0]       offset,
   output logic        [SAMPLE_BITS-1:0]       span,
   output logic        [mhsi_pkg::SCALE_BITS-1:0] scale,
   output logic                                sat
);
   import mhsi_pkg::*;

   localparam int DIV_BITS  = SAMPLE_BITS + SCALE_FRAC_BITS;
   localparam int WIDE_BITS = (DIV_BITS > SCALE_BITS) ? DIV_BITS : SCALE_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic        [DIV_BITS-1:0]    quo_ff, quo_in;
   logic        [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic signed [SAMPLE_BITS:0]   sum;
   logic signed [SAMPLE_BITS:0]   diff;
   logic        [SAMPLE_BITS:0]   trial;
   logic        [SAMPLE_BITS:0]   trial_diff;
   logic        [WIDE_BITS-1:0]   quo_wide;
   logic                          over;

   // Min/max tracking
   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (ctrl.update) begin
         if (sample > max_ff) max_in = sample;
         if (sample < min_ff) min_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MOST_NEG;
         min_ff <= MOST_POS;
      end else begin
         max_ff <= max_in;
         min_ff <= min_in;
      end
   end

   // Floor midpoint is an arithmetic shift of the widened sum
   assign sum    = {max_ff[SAMPLE_BITS-1], max_ff} + {min_ff[SAMPLE_BITS-1], min_ff};
   assign offset = sum[SAMPLE_BITS:1];
   assign diff   = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign span   = diff[SAMPLE_BITS] ? '0 : diff[SAMPLE_BITS-1:0];

   // Restoring division: quotient bits shift in as dividend bits shift out
   assign trial      = {rem_ff, quo_ff[DIV_BITS-1]};
   assign trial_diff = trial - {1'b0, span};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (ctrl.start) begin
         quo_in = {widest, {SCALE_FRAC_BITS{1'b0}}};
         rem_in = '0;
      end else if (ctrl.step) begin
         if (!trial_diff[SAMPLE_BITS]) begin
            rem_in = trial_diff[SAMPLE_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SAMPLE_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // Saturate on zero span or quotient overflow
   assign quo_wide = WIDE_BITS'(quo_ff);
   assign over     = |(quo_wide >> SCALE_BITS);
   assign sat      = (span == '0) || over;
   assign scale    = sat ? {SCALE_BITS{1'b1}} : quo_wide[SCALE_BITS-1:0];

endmodule

FILE: sv/mhsi_merge.sv
// Merge stage: widest span across the lanes and the combined saturation flag.
`timescale 1ns / 1ps

module mhsi_merge #(
   parameter int SAMPLE_BITS = mhsi_pkg::SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0]    span [mhsi_pkg::AXES],
   input  logic [mhsi_pkg::AXES-1:0] lane_sat,
   output logic [SAMPLE_BITS-1:0]    widest,
   output logic                      any_sat
);
   import mhsi_pkg::*;

   always_comb begin
      widest = '0;
      for (int a = 0; a < AXES; a++) begin
         if (span[a] > widest) widest = span[a];
      end
   end

   assign any_sat = |lane_sat;

endmodule

FILE: sv/mag_hard_soft_iron_calibrator.sv
// Top level of the min/max hard-iron and soft-iron magnetometer calibrator.
`timescale 1ns / 1ps
//
// Usage:
//   Each request on req_ carries one three-axis sample (signed, 1/16 uT).
//   Each request gives exactly one response on rsp_: per-axis hard-iron
//   offsets floor((min+max)/2), per-axis soft-iron scales in unsigned Q4.12
//   (widest span / axis span) and a saturation flag on rsp_tuser.
// Sequence:
//   A request passes through the sequencer states in order: the accept edge
//   folds the sample into min/max, the merge state picks the widest span and
//   loads the dividers, the divide state runs the three lane dividers side by
//   side at one quotient bit per cycle, and the emit state loads the output
//   register once it is free. The bit-serial lane dividers set the rate: the
//   port reopens right after that load, so the block takes no new request
//   while one is still in flight.
// Reset:
//   Synchronous, active high. Maxima go to the most negative value and
//   minima to the most positive, so the first sample sets both.
// Stall:
//   A finished response waits in the output register while rsp_tready is
//   low; the next request may be accepted and worked on meanwhile, and only
//   its final load into the output register holds until the old one leaves.

module mag_hard_soft_iron_calibrator #(
   parameter int SAMPLE_BITS     = mhsi_pkg::SAMPLE_BITS_DEF,
   parameter int SCALE_FRAC_BITS = mhsi_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // req_tdata, low bit up: sample_x, sample_y, sample_z, zero pad
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((mhsi_pkg::AXES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // rsp_tdata, low bit up: offset_x, offset_y, offset_z,
   //                        scale_x, scale_y, scale_z, zero pad
   // rsp_tuser: scale_saturated
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((mhsi_pkg::AXES*(SAMPLE_BITS+mhsi_pkg::SCALE_BITS)+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tuser
);
   import mhsi_pkg::*;

   localparam int REQ_BITS  = ((AXES*SAMPLE_BITS+7)/8)*8;
   localparam int RSP_BITS  = ((AXES*(SAMPLE_BITS+SCALE_BITS)+7)/8)*8;
   localparam int SCALE_LSB = AXES*SAMPLE_BITS;
   localparam int DIV_BITS  = SAMPLE_BITS + SCALE_FRAC_BITS;
   localparam int CNT_BITS  = $clog2(DIV_BITS+1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_BITS-1);
   localparam logic [SCALE_BITS-1:0] SCALE_MAX = {SCALE_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_BITS-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tuser_ff, rsp_tuser_in;
   logic                    req_accept;
   logic                    out_free;
   lane_ctrl_type           ctrl;

   logic signed [SAMPLE_BITS-1:0] lane_sample [AXES];
   logic signed [SAMPLE_BITS-1:0] lane_offset [AXES];
   logic        [SAMPLE_BITS-1:0] lane_span   [AXES];
   logic        [SCALE_BITS-1:0]  lane_scale  [AXES];
   logic        [AXES-1:0]        lane_sat;
   logic        [SAMPLE_BITS-1:0] widest;
   logic                          any_sat;
   logic [REQ_BITS-1:0]           req_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_data   = req_tdata;

   // Lane controls follow the sequencer state
   assign ctrl.update = req_accept;
   assign ctrl.start  = (state_ff == ST_MERGE);
   assign ctrl.step   = (state_ff == ST_DIVIDE);

   // Three axis lanes working side by side
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      assign lane_sample[a] = req_data[a*SAMPLE_BITS +: SAMPLE_BITS];

      mhsi_lane #(
         .SAMPLE_BITS     (SAMPLE_BITS),
         .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sample (lane_sample[a]),
         .widest (widest),
         .offset (lane_offset[a]),
         .span   (lane_span[a]),
         .scale  (lane_scale[a]),
         .sat    (lane_sat[a])
      );
   end

   // Combine what the lanes found: widest span, any saturation
   mhsi_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .span     (lane_span),
      .lane_sat (lane_sat),
      .widest   (widest),
      .any_sat  (any_sat)
   );

   // Pack the response word, offsets low, scales above them
   always_comb begin
      rsp_tdata_in = '0;
      for (int a = 0; a < AXES; a++) begin
         rsp_tdata_in[a*SAMPLE_BITS +: SAMPLE_BITS]          = lane_offset[a];
         rsp_tdata_in[SCALE_LSB + a*SCALE_BITS +: SCALE_BITS] = lane_scale[a];
      end
      rsp_tuser_in = any_sat;
   end

   // Sequencer: accept, merge, divide, then emit once the output is free
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         // Hold the payload until the response leaves
         if (state_ff == ST_EMIT && out_free) begin
            rsp_tdata_ff <= rsp_tdata_in;
            rsp_tuser_ff <= rsp_tuser_in;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef NO_ASSERTIONS
   // One request at a time: the port closes right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a previous one is in flight");

   // A saturated response carries at least one saturated scale
   a_sat_has_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[SCALE_LSB +: SCALE_BITS] == SCALE_MAX) ||
         (rsp_tdata[SCALE_LSB + SCALE_BITS +: SCALE_BITS] == SCALE_MAX) ||
         (rsp_tdata[SCALE_LSB + 2*SCALE_BITS +: SCALE_BITS] == SCALE_MAX))
      else $error("saturation flag without a saturated scale");

   // Divider step count stays within the quotient width
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> cnt_ff < CNT_BITS'(DIV_BITS))
      else $error("divider ran past the last quotient bit");
`endif

endmodule
